// File: hw/rtl/mtbs_pkg.sv
// Package for the markup tag balance stack: sizes, codes and the request,
// command and result types shared by the front, queue and back modules.
// No dependencies.
package mtbs_pkg;

	// Tag stack size
	localparam int STACK_DEPTH = 64;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int TOK_W   = 8;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_CLOSE_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_CLOSE_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_CLOSE_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_CLOSE_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BODY_TOKEN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CARD_TOKEN   = 3'd5;

	// Request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_END   = 1'b1;

	// Notification kinds
	localparam logic EV_START = 1'b0;
	localparam logic EV_END   = 1'b1;

	// End completion codes
	localparam logic [1:0] COMP_NORMAL   = 2'd0;
	localparam logic [1:0] COMP_FALLBACK = 2'd1;
	localparam logic [1:0] COMP_NOTSTART = 2'd2;

	typedef struct packed {
		logic             req_type;
		logic [TOK_W-1:0] tag_token;
		logic             is_empty;
	} in_item_t;

	typedef struct packed {
		logic             event_kind;
		logic [TOK_W-1:0] out_token;
		logic [1:0]       completion;
		logic             empty_flag;
		logic             overflow;
		logic             last;
	} out_item_t;

	// Classified request as queued for the back end
	typedef struct packed {
		logic             req_type;
		logic [TOK_W-1:0] tok;
		logic             is_empty;
		logic             self_close;
		logic             not_start;
	} cmd_t;

endpackage

// File: hw/rtl/mtbs_front.sv
// Front end: configuration registers and request classification.
// Depends on mtbs_pkg.
module mtbs_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  mtbs_pkg::in_item_t                req,
	output logic                              busy,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mtbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtbs_pkg::TOK_W-1:0]        cfg_data,
	input  logic                              q_full,
	output logic                              push,
	output mtbs_pkg::cmd_t                    cmd
);
	import mtbs_pkg::*;

	logic [TOK_W-1:0] sc_a_q, sc_b_q, sc_c_q, sc_d_q, body_q, card_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_a_q <= '0;
			sc_b_q <= '0;
			sc_c_q <= '0;
			sc_d_q <= '0;
			body_q <= '0;
			card_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SELF_CLOSE_A: sc_a_q <= cfg_data;
				CFG_SELF_CLOSE_B: sc_b_q <= cfg_data;
				CFG_SELF_CLOSE_C: sc_c_q <= cfg_data;
				CFG_SELF_CLOSE_D: sc_d_q <= cfg_data;
				CFG_BODY_TOKEN:   body_q <= cfg_data;
				CFG_CARD_TOKEN:   card_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify and hand to the queue
	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		cmd.req_type   = req.req_type;
		cmd.tok        = req.tag_token;
		cmd.is_empty   = req.is_empty;
		cmd.self_close = (req.tag_token == sc_a_q) || (req.tag_token == sc_b_q) ||
		                 (req.tag_token == sc_c_q) || (req.tag_token == sc_d_q);
		cmd.not_start  = (req.tag_token == body_q) || (req.tag_token == card_q);
	end

endmodule

// File: hw/rtl/mtbs_queue.sv
// Short command FIFO between front and back end.
// Depends on mtbs_pkg.
module mtbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtbs_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output logic           not_empty,
	output logic           full,
	output mtbs_pkg::cmd_t rd_cmd
);
	import mtbs_pkg::*;

	cmd_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_cmd    = ent_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= wr_cmd;
		end
	end

endmodule

// File: hw/rtl/mtbs_back.sv
// Back end: tag stack memory, stack count and the sequencer that issues
// start and end notifications, including the stack scan and fallback pops.
// Depends on mtbs_pkg.
module mtbs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  mtbs_pkg::cmd_t     cmd,
	output logic               q_pop,
	output logic               result_valid,
	output mtbs_pkg::out_item_t result
);
	import mtbs_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SC_END  = 3'd1;
	localparam logic [2:0] ST_TOP_CHK = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_POP_CHK = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m1, cnt_m2, budget;
	logic [CNT_W-1:0] scan_q, scan_d, pops_q, pops_d;
	logic [TOK_W-1:0] tok_q, tok_d, top_q, top_d, rd_q;
	logic             nst_q, nst_d, rv_q, rv_d;
	logic             res_v_q, res_v_d;
	out_item_t        res_q, res_d;
	logic             mem_we, hit, fin;
	logic [IDX_W-1:0] rd_addr;
	logic [TOK_W-1:0] mem [STACK_DEPTH];

	function automatic out_item_t mk_start(logic [TOK_W-1:0] t, logic e, logic o,
	                                       logic l);
		out_item_t r;
		r.event_kind = EV_START;
		r.out_token  = t;
		r.completion = COMP_NORMAL;
		r.empty_flag = e;
		r.overflow   = o;
		r.last       = l;
		return r;
	endfunction

	function automatic out_item_t mk_end(logic [TOK_W-1:0] t, logic [1:0] c, logic l);
		out_item_t r;
		r.event_kind = EV_END;
		r.out_token  = t;
		r.completion = c;
		r.empty_flag = 1'b0;
		r.overflow   = 1'b0;
		r.last       = l;
		return r;
	endfunction

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign cnt_m2 = cnt_q - CNT_W'(2);
	assign budget = cnt_m1 >> 1;
	assign hit    = (rd_q == tok_q);
	assign fin    = hit || (pops_q == CNT_W'(1));

	// Sequencer
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		tok_d   = tok_q;
		nst_d   = nst_q;
		top_d   = top_q;
		scan_d  = scan_q;
		pops_d  = pops_q;
		rv_d    = 1'b0;
		res_d   = res_q;
		res_v_d = 1'b0;
		q_pop   = 1'b0;
		mem_we  = 1'b0;
		rd_addr = cnt_m1[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					tok_d = cmd.tok;
					nst_d = cmd.not_start;
					if (cmd.req_type == REQ_START) begin
						res_v_d = 1'b1;
						priority if (cmd.self_close) begin
							res_d   = mk_start(cmd.tok, cmd.is_empty, 1'b0, 1'b0);
							state_d = ST_SC_END;
						end else if (cnt_q == CNT_W'(STACK_DEPTH)) begin
							res_d = mk_start(cmd.tok, cmd.is_empty, 1'b1, 1'b1);
						end else if (cmd.is_empty) begin
							// pushed and popped at once: stack unchanged
							res_d   = mk_start(cmd.tok, 1'b1, 1'b0, 1'b0);
							state_d = ST_SC_END;
						end else begin
							mem_we = 1'b1;
							cnt_d  = cnt_q + CNT_W'(1);
							res_d  = mk_start(cmd.tok, 1'b0, 1'b0, 1'b1);
						end
					end else if (!cmd.self_close && cnt_q != '0) begin
						// top read issued here
						state_d = ST_TOP_CHK;
					end
				end
			end
			ST_SC_END: begin
				res_v_d = 1'b1;
				res_d   = mk_end(tok_q, COMP_NORMAL, 1'b1);
				state_d = ST_IDLE;
			end
			ST_TOP_CHK: begin
				if (hit) begin
					res_v_d = 1'b1;
					res_d   = mk_end(rd_q, COMP_NORMAL, 1'b1);
					cnt_d   = cnt_m1;
					state_d = ST_IDLE;
				end else begin
					top_d   = rd_q;
					scan_d  = '0;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// one read issued and one compare per cycle
				rd_addr = scan_q[IDX_W-1:0];
				if (scan_q != cnt_q) begin
					scan_d = scan_q + CNT_W'(1);
					rv_d   = 1'b1;
				end
				priority if (rv_q && hit) begin
					res_v_d = 1'b1;
					res_d   = mk_end(top_q, COMP_FALLBACK, 1'b0);
					cnt_d   = cnt_m1;
					pops_d  = (budget == '0) ? CNT_W'(1) : budget;
					rd_addr = cnt_m2[IDX_W-1:0];
					rv_d    = 1'b0;
					state_d = ST_POP_CHK;
				end else if (!rv_q && scan_q == cnt_q) begin
					res_v_d = nst_q;
					res_d   = mk_end(tok_q, COMP_NOTSTART, 1'b1);
					state_d = ST_IDLE;
				end else begin
				end
			end
			ST_POP_CHK: begin
				// one pop per cycle, next top read in flight
				res_v_d = 1'b1;
				res_d   = mk_end(rd_q, hit ? COMP_NORMAL : COMP_FALLBACK, fin);
				cnt_d   = cnt_m1;
				pops_d  = pops_q - CNT_W'(1);
				rd_addr = cnt_m2[IDX_W-1:0];
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rv_q    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rv_q    <= rv_d;
			res_v_q <= res_v_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		tok_q  <= tok_d;
		nst_q  <= nst_d;
		top_q  <= top_d;
		scan_q <= scan_d;
		pops_q <= pops_d;
		res_q  <= res_d;
	end

	// Tag stack memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[IDX_W-1:0]] <= cmd.tok;
		end
		rd_q <= mem[rd_addr];
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

	// The final result of a request always returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && res_q.last |-> state_q == ST_IDLE)
		else $error("last result issued while sequencer busy");

	// Stack count moves by at most one per cycle
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |->
			(cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("stack count jumped");

	// Overflow is only flagged on a full stack
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && res_q.overflow |-> $past(cnt_q) == CNT_W'(STACK_DEPTH))
		else $error("overflow flagged on a stack that was not full");

	// Pops never run on an empty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_CHK) || (state_q == ST_TOP_CHK) |-> cnt_q != '0)
		else $error("pop on empty stack");

	// Count never exceeds the stack size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cnt_q) == CNT_W'(STACK_DEPTH) |-> cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

endmodule

// File: hw/rtl/markup_tag_balance_stack.sv
// Markup tag balance stack, top level: front end, command queue, back end.
// Depends on mtbs_pkg, mtbs_front, mtbs_queue, mtbs_back.
// Path (idle back end): a start notification leaves the queue entry through the IDLE state into the result
//   register; a matching end first passes the top-read check. Other end tags scan the stack one entry per cycle,
//   then pop one tag per cycle; new requests queue while the back end is busy; results never wait.
// Reset clears config, stack count and queue; stack memory is not cleared.
module markup_tag_balance_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  mtbs_pkg::in_item_t             req,
	output logic                           busy,
	output logic                           result_valid,
	output mtbs_pkg::out_item_t            result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mtbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mtbs_pkg::TOK_W-1:0]     cfg_data
);
	import mtbs_pkg::*;

	logic push, q_full, q_valid, q_pop;
	cmd_t wr_cmd, rd_cmd;

	// Request intake and classification
	mtbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.cmd       (wr_cmd)
	);

	// Command queue
	mtbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.pop       (q_pop),
		.not_empty (q_valid),
		.full      (q_full),
		.rd_cmd    (rd_cmd)
	);

	// Stack and notification sequencer
	mtbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.cmd          (rd_cmd),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// File: test/tb_markup_tag_balance_stack.sv
// Self-checking testbench for markup_tag_balance_stack: directed and random tag event
// streams are checked against an in-bench model of the open-tag stack.
// Depends on mtbs_pkg and the markup_tag_balance_stack RTL.
`timescale 1ns / 100ps

module tb_markup_tag_balance_stack;
	import mtbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_TAIL     = 4 * STACK_DEPTH + 16;
	localparam logic [TOK_W-1:0] BOTTOM_TOKEN = 8'h5A;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	in_item_t             req;
	logic                 busy;
	logic                 result_valid;
	out_item_t            result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TOK_W-1:0]     cfg_data;

	// Tag stack model and register shadow
	logic [TOK_W-1:0] tag_stack [0:STACK_DEPTH-1];
	int               open_depth;
	logic [TOK_W-1:0] reg_shadow [0:5];
	out_item_t        expected_notes [$];
	out_item_t        oldest_note;
	int               item_note_count;

	// Run statistics
	int mismatches     = 0;
	int events_sent    = 0;
	int events_noted   = 0;
	int notes_checked  = 0;
	int fallback_seen  = 0;
	int notstart_seen  = 0;
	int overflow_seen  = 0;
	int idle_cycles    = 0;

	markup_tag_balance_stack u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (req),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Stack model
	// ---------------------------------------------------------------
	function automatic bit is_self_closing(logic [TOK_W-1:0] tok);
		return tok == reg_shadow[CFG_SELF_CLOSE_A] || tok == reg_shadow[CFG_SELF_CLOSE_B] ||
		       tok == reg_shadow[CFG_SELF_CLOSE_C] || tok == reg_shadow[CFG_SELF_CLOSE_D];
	endfunction

	function automatic bit tag_on_stack(logic [TOK_W-1:0] tok);
		for (int i = 0; i < open_depth; i++) begin
			if (tag_stack[i] == tok)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic queue_note(input logic kind, input logic [TOK_W-1:0] tok,
			input logic [1:0] comp, input logic empty, input logic ovf, inout int n);
		out_item_t note;
		note.event_kind = kind;
		note.out_token  = tok;
		note.completion = comp;
		note.empty_flag = empty;
		note.overflow   = ovf;
		note.last       = 1'b0;
		expected_notes.push_back(note);
		n++;
	endtask

	// End tag handling: exact pop, not-started report, or fallback walk
	task automatic close_open_tag(input logic [TOK_W-1:0] tok, inout int n);
		logic [TOK_W-1:0] top;
		int               budget;
		bit               hit;
		if (is_self_closing(tok) || open_depth == 0)
			return;
		top = tag_stack[open_depth-1];
		if (top == tok) begin
			open_depth--;
			queue_note(EV_END, top, COMP_NORMAL, 1'b0, 1'b0, n);
			return;
		end
		if (!tag_on_stack(tok)) begin
			if (tok == reg_shadow[CFG_BODY_TOKEN] || tok == reg_shadow[CFG_CARD_TOKEN])
				queue_note(EV_END, tok, COMP_NOTSTART, 1'b0, 1'b0, n);
			return;
		end
		open_depth--;
		queue_note(EV_END, tag_stack[open_depth], COMP_FALLBACK, 1'b0, 1'b0, n);
		// walk at most half of what is left, always at least one more pop
		budget = open_depth / 2;
		hit    = 1'b0;
		do begin
			if (open_depth == 0)
				break;
			open_depth--;
			top = tag_stack[open_depth];
			hit = (top == tok);
			queue_note(EV_END, top, hit ? COMP_NORMAL : COMP_FALLBACK, 1'b0, 1'b0, n);
			if (budget > 0)
				budget--;
		end while (budget > 0 && !hit);
	endtask

	task automatic predict_notes(input in_item_t it);
		int        n;
		out_item_t tail;
		n = 0;
		if (it.req_type == REQ_START) begin
			if (is_self_closing(it.tag_token)) begin
				queue_note(EV_START, it.tag_token, COMP_NORMAL, it.is_empty, 1'b0, n);
				queue_note(EV_END, it.tag_token, COMP_NORMAL, 1'b0, 1'b0, n);
			end else if (open_depth >= STACK_DEPTH) begin
				queue_note(EV_START, it.tag_token, COMP_NORMAL, it.is_empty, 1'b1, n);
			end else begin
				tag_stack[open_depth] = it.tag_token;
				open_depth++;
				queue_note(EV_START, it.tag_token, COMP_NORMAL, it.is_empty, 1'b0, n);
				if (it.is_empty)
					close_open_tag(it.tag_token, n);
			end
		end else begin
			close_open_tag(it.tag_token, n);
		end
		// flag the final notification of this event
		if (n > 0) begin
			tail = expected_notes.pop_back();
			tail.last = 1'b1;
			expected_notes.push_back(tail);
		end
		item_note_count = n;
	endtask

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	task automatic send_tag_event(input logic kind, input logic [TOK_W-1:0] tok,
			input logic empty);
		in_item_t it;
		it.req_type  = kind;
		it.tag_token = tok;
		it.is_empty  = empty;
		@(negedge clk);
		start <= 1'b1;
		req   <= it;
		do @(posedge clk); while (busy);
		predict_notes(it);
		events_sent++;
		if (item_note_count > 0)
			events_noted++;
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Hold off until every notification is in and the block has gone quiet
	task automatic settle_block();
		@(negedge clk);
		start <= 1'b0;
		while (expected_notes.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOK_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		reg_shadow[idx] = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(input logic [TOK_W-1:0] sc_a, input logic [TOK_W-1:0] sc_b,
			input logic [TOK_W-1:0] sc_c, input logic [TOK_W-1:0] sc_d,
			input logic [TOK_W-1:0] body, input logic [TOK_W-1:0] card);
		settle_block();
		write_reg(CFG_SELF_CLOSE_A, sc_a);
		write_reg(CFG_SELF_CLOSE_B, sc_b);
		write_reg(CFG_SELF_CLOSE_C, sc_c);
		write_reg(CFG_SELF_CLOSE_D, sc_d);
		write_reg(CFG_BODY_TOKEN, body);
		write_reg(CFG_CARD_TOKEN, card);
	endtask

	// Close against the bottom entry until the stack is empty; long fallback walks
	task automatic unwind_stack();
		while (open_depth > 0 && !is_self_closing(tag_stack[0]))
			send_tag_event(REQ_END, tag_stack[0], 1'b0);
	endtask

	// ---------------------------------------------------------------
	// Random token choice
	// ---------------------------------------------------------------
	function automatic logic [TOK_W-1:0] pick_start_token();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'h20 + 8'($urandom_range(0, 7));
		else if (r < 85)
			return reg_shadow[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [TOK_W-1:0] pick_end_token();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50 && open_depth > 0)
			return tag_stack[open_depth-1];
		if (r < 70 && open_depth > 0)
			return tag_stack[$urandom_range(0, open_depth - 1)];
		if (r < 80)
			return $urandom_range(0, 1) ? reg_shadow[CFG_BODY_TOKEN] : reg_shadow[CFG_CARD_TOKEN];
		if (r < 88)
			return reg_shadow[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Reset registers: token 0 is self-closing and also body/card
	task automatic test_reset_defaults();
		send_tag_event(REQ_START, 8'h00, 1'b0);
		send_tag_event(REQ_END, 8'h00, 1'b0);
		send_tag_event(REQ_END, 8'hFF, 1'b0);
		send_tag_event(REQ_START, 8'hFF, 1'b1);
	endtask

	task automatic test_self_closing();
		send_tag_event(REQ_START, 8'hFF, 1'b1);
		send_tag_event(REQ_START, 8'hC3, 1'b0);
		send_tag_event(REQ_START, 8'h3C, 1'b0);
		send_tag_event(REQ_START, 8'h01, 1'b1);
		send_tag_event(REQ_END, 8'hFF, 1'b0);
	endtask

	task automatic test_matched_ends();
		send_tag_event(REQ_START, 8'h11, 1'b0);
		send_tag_event(REQ_START, 8'h22, 1'b0);
		send_tag_event(REQ_END, 8'h22, 1'b0);
		send_tag_event(REQ_START, 8'h33, 1'b1);
		send_tag_event(REQ_END, 8'h11, 1'b0);
	endtask

	// Body/card on an empty stack say nothing; with open tags they report not started
	task automatic test_not_started();
		send_tag_event(REQ_END, 8'h00, 1'b0);
		send_tag_event(REQ_START, 8'h44, 1'b0);
		send_tag_event(REQ_END, 8'h00, 1'b0);
		send_tag_event(REQ_END, 8'h80, 1'b0);
		send_tag_event(REQ_END, 8'h55, 1'b0);
		send_tag_event(REQ_END, 8'h44, 1'b0);
	endtask

	// Walk that runs out of budget, exact pop, and a walk with zero budget left
	task automatic test_fallback_walk();
		for (int i = 0; i < 6; i++)
			send_tag_event(REQ_START, 8'h10 + 8'(i), 1'b0);
		send_tag_event(REQ_END, 8'h11, 1'b0);
		send_tag_event(REQ_END, 8'h12, 1'b0);
		send_tag_event(REQ_END, 8'h10, 1'b0);
		send_tag_event(REQ_START, 8'h10, 1'b1);
	endtask

	// Fill the stack, push past the top (plain and empty), then unwind
	task automatic test_overflow();
		logic [TOK_W-1:0] tok;
		unwind_stack();
		send_tag_event(REQ_START, BOTTOM_TOKEN, 1'b0);
		while (open_depth < STACK_DEPTH) begin
			do tok = 8'($urandom_range(0, 255));
			while (is_self_closing(tok) || tok == BOTTOM_TOKEN);
			send_tag_event(REQ_START, tok, 1'b0);
			if ($urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 3));
		end
		send_tag_event(REQ_START, 8'h66, 1'b0);
		send_tag_event(REQ_START, 8'h67, 1'b1);
		send_tag_event(REQ_START, BOTTOM_TOKEN, 1'b0);
		unwind_stack();
	endtask

	// Bursts biased toward filling, draining or mixing the stack
	task automatic test_random_stream(input int n_items, input bit no_gaps);
		int   counted;
		int   burst;
		int   p_start;
		logic kind;
		counted = 0;
		while (counted < n_items) begin
			burst = $urandom_range(1, 12);
			case ($urandom_range(0, 2))
				0: p_start = 85;
				1: p_start = 25;
				default: p_start = 50;
			endcase
			repeat (burst) begin
				kind = ($urandom_range(0, 99) < p_start) ? REQ_START : REQ_END;
				if (kind == REQ_START)
					send_tag_event(REQ_START, pick_start_token(),
						($urandom_range(0, 99) < 15) ? 1'b1 : 1'b0);
				else
					send_tag_event(REQ_END, pick_end_token(), 1'($urandom_range(0, 1)));
				counted++;
			end
			if (!no_gaps && $urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 6));
		end
	endtask

	// ---------------------------------------------------------------
	// Notification checker
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_notes.size() == 0) begin
				$display("%0t: unexpected notification, expected none, actual %h",
					$time, result);
				mismatches++;
			end else begin
				oldest_note = expected_notes.pop_front();
				check_field("event_kind", oldest_note.event_kind, result.event_kind);
				check_field("out_token", oldest_note.out_token, result.out_token);
				check_field("completion", oldest_note.completion, result.completion);
				check_field("empty_flag", oldest_note.empty_flag, result.empty_flag);
				check_field("overflow", oldest_note.overflow, result.overflow);
				check_field("last", oldest_note.last, result.last);
				notes_checked++;
				if (result.completion == COMP_FALLBACK && result.event_kind == EV_END)
					fallback_seen++;
				if (result.completion == COMP_NOTSTART && result.event_kind == EV_END)
					notstart_seen++;
				if (result.overflow)
					overflow_seen++;
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no progress for %0d cycles", $time, idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		open_depth = 0;
		for (int i = 0; i < 6; i++)
			reg_shadow[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		apply_config(8'hFF, 8'hC3, 8'h3C, 8'h01, 8'h00, 8'h80);
		test_self_closing();
		test_matched_ends();
		test_not_started();
		test_fallback_walk();
		test_overflow();
		test_random_stream(59, 1'b1);

		// shared token: self-closing wins over card
		apply_config(8'h22, 8'h22, 8'h22, 8'hFE, 8'hFF, 8'h22);
		test_random_stream(59, 1'b0);

		apply_config(8'h00, 8'h7F, 8'h80, 8'h24, 8'h21, 8'h00);
		test_random_stream(59, 1'b0);

		settle_block();
		$display("Sent %0d tag events (%0d with notifications); %0d notifications checked,",
			events_sent, events_noted, notes_checked);
		$display("with %0d fallback ends, %0d not-started ends, %0d overflowed starts.",
			fallback_seen, notstart_seen, overflow_seen);
		if (mismatches == 0 && expected_notes.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d notifications still expected",
				mismatches, expected_notes.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
